@@ rtl/core/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// Shortest common supersequence package
// Shared types and constants for the supersequence block.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int MAX_LEN_DEF = 32;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_FIRST   = 2'd0,
      KIND_SECOND  = 2'd1,
      KIND_COMPUTE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
      logic       empty_res;
      logic       overflow;
   } rsp_type;

endpackage

@@ rtl/core/scs_queue.sv @@
// ----------------------------------------------------------------------------
// Request queue
// Small queue between the front part and the back part.
// ----------------------------------------------------------------------------
module scs_queue
   import scs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    full,
   input  req_type wr_data,
   output logic    rd_valid,
   input  logic    rd_take,
   output req_type rd_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   req_type         mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign full     = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && !full;
   assign pop      = rd_take && rd_valid;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/scs_engine.sv @@
// ----------------------------------------------------------------------------
// Supersequence engine
// Stores both strings, fills the LCS table, traces one LCS and emits the
// supersequence one byte per step.
// ----------------------------------------------------------------------------
module scs_engine
   import scs_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_take,
   input  req_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int TDIM = MAX_LEN + 1;
   localparam int TW   = $clog2(TDIM * TDIM);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_FILL  = 9'b000000010,
      ST_FRD   = 9'b000000100,
      ST_FWR   = 9'b000001000,
      ST_TRD   = 9'b000010000,
      ST_TDEC  = 9'b000100000,
      ST_WALK  = 9'b001000000,
      ST_WRD   = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff;

   logic [7:0] s1_mem [MAX_LEN];
   logic [7:0] s2_mem [MAX_LEN];
   logic [7:0] sub_mem [MAX_LEN];
   logic [LW-1:0] tbl_mem [TDIM * TDIM];

   logic [LW-1:0] n_ff, m_ff, i_ff, j_ff, nsub_ff, k_ff, p1_ff, p2_ff;
   logic          drop_ff;
   logic [LW-1:0] a_ff, b_ff, d_ff;
   logic [1:0]    rdsel_ff;
   logic [7:0]    c1_ff, c2_ff, cs_ff;
   logic [TW-1:0] raddr;
   logic [LW-1:0] rdata_ff;
   logic          tie_ff;
   logic          out_v_ff;
   rsp_type       out_ff;
   logic          out_free;
   logic          out_load;

   logic [TW-1:0] cell_ij, cell_i1j, cell_ij1, cell_i1j1;
   assign cell_ij   = TW'(i_ff) * TW'(TDIM) + TW'(j_ff);
   assign cell_i1j  = cell_ij + TW'(TDIM);
   assign cell_ij1  = cell_ij + TW'(1);
   assign cell_i1j1 = cell_ij + TW'(TDIM + 1);

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   assign out_free = !out_v_ff || !rsp_stall;
   assign in_take  = (state_ff == ST_IDLE) && in_valid;
   assign out_load = out_free && ((state_ff == ST_EMIT) ||
                     ((state_ff == ST_WRD) &&
                      (k_ff < nsub_ff || p1_ff < n_ff || p2_ff < m_ff)));

   always_ff @(posedge clock) begin
      rdata_ff <= tbl_mem[raddr];
   end

   always_comb begin
      unique case (rdsel_ff)
         2'd0:    raddr = cell_i1j;
         2'd1:    raddr = cell_ij1;
         default: raddr = cell_i1j1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         m_ff     <= '0;
         drop_ff  <= 1'b0;
         rdsel_ff <= 2'd0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  case (in_data.kind)
                     KIND_FIRST: begin
                        if (n_ff < LW'(MAX_LEN)) begin
                           s1_mem[n_ff[IW-1:0]] <= in_data.char_in;
                           n_ff <= n_ff + 1'b1;
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     KIND_SECOND: begin
                        if (m_ff < LW'(MAX_LEN)) begin
                           s2_mem[m_ff[IW-1:0]] <= in_data.char_in;
                           m_ff <= m_ff + 1'b1;
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     KIND_COMPUTE: begin
                        if (n_ff == '0 && m_ff == '0) begin
                           state_ff <= ST_EMIT;
                        end else begin
                           i_ff     <= n_ff;
                           j_ff     <= m_ff;
                           state_ff <= ST_FILL;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            // Walk cells from (n,m) downward in row-major reverse order.
            ST_FILL: begin
               if (i_ff == n_ff || j_ff == m_ff) begin
                  tbl_mem[cell_ij] <= '0;
                  if (j_ff == '0) begin
                     if (i_ff == '0) begin
                        i_ff <= '0; j_ff <= '0; nsub_ff <= '0;
                        state_ff <= ST_TRD;
                     end else begin
                        i_ff <= i_ff - 1'b1; j_ff <= m_ff;
                     end
                  end else begin
                     j_ff <= j_ff - 1'b1;
                  end
               end else begin
                  c1_ff    <= s1_mem[i_ff[IW-1:0]];
                  c2_ff    <= s2_mem[j_ff[IW-1:0]];
                  rdsel_ff <= 2'd0;
                  state_ff <= ST_FRD;
               end
            end
            ST_FRD: begin
               if (rdsel_ff == 2'd0) begin
                  rdsel_ff <= 2'd1;
               end else if (rdsel_ff == 2'd1) begin
                  a_ff <= rdata_ff; rdsel_ff <= 2'd2;
               end else if (rdsel_ff == 2'd2) begin
                  b_ff <= rdata_ff; rdsel_ff <= 2'd3;
               end else begin
                  d_ff <= rdata_ff; state_ff <= ST_FWR;
               end
            end
            ST_FWR: begin
               if (c1_ff == c2_ff) begin
                  tbl_mem[cell_ij] <= d_ff + 1'b1;
               end else begin
                  tbl_mem[cell_ij] <= (a_ff >= b_ff) ? a_ff : b_ff;
               end
               if (j_ff == '0) begin
                  if (i_ff == '0) begin
                     nsub_ff <= '0;
                     state_ff <= ST_TRD;
                  end else begin
                     i_ff <= i_ff - 1'b1; j_ff <= m_ff;
                     state_ff <= ST_FILL;
                  end
               end else begin
                  j_ff <= j_ff - 1'b1;
                  state_ff <= ST_FILL;
               end
            end
            ST_TRD: begin
               if (i_ff < n_ff && j_ff < m_ff && nsub_ff < LW'(MAX_LEN)) begin
                  c1_ff    <= s1_mem[i_ff[IW-1:0]];
                  c2_ff    <= s2_mem[j_ff[IW-1:0]];
                  rdsel_ff <= 2'd0;
                  state_ff <= ST_TDEC;
                  tie_ff   <= 1'b0;
               end else begin
                  k_ff <= '0; p1_ff <= '0; p2_ff <= '0;
                  state_ff <= ST_WALK;
               end
            end
            ST_TDEC: begin
               if (c1_ff == c2_ff) begin
                  sub_mem[nsub_ff[IW-1:0]] <= c1_ff;
                  nsub_ff <= nsub_ff + 1'b1;
                  i_ff <= i_ff + 1'b1; j_ff <= j_ff + 1'b1;
                  state_ff <= ST_TRD;
               end else if (rdsel_ff == 2'd0) begin
                  rdsel_ff <= 2'd1;
               end else if (!tie_ff) begin
                  a_ff <= rdata_ff; tie_ff <= 1'b1;
               end else begin
                  if (a_ff >= rdata_ff) begin
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
                  state_ff <= ST_TRD;
               end
            end
            ST_WALK: begin
               if (k_ff < nsub_ff) begin
                  cs_ff <= sub_mem[k_ff[IW-1:0]];
               end
               c1_ff <= s1_mem[p1_ff[IW-1:0]];
               c2_ff <= s2_mem[p2_ff[IW-1:0]];
               state_ff <= ST_WRD;
            end
            ST_WRD: begin
               if (out_free) begin
                  if (k_ff < nsub_ff) begin
                     out_ff.empty_res <= 1'b0;
                     out_ff.overflow  <= drop_ff;
                     if (p1_ff < n_ff && c1_ff != cs_ff) begin
                        out_ff.char_out <= c1_ff; out_ff.last <= 1'b0;
                        p1_ff <= p1_ff + 1'b1;
                     end else if (p2_ff < m_ff && c2_ff != cs_ff) begin
                        out_ff.char_out <= c2_ff; out_ff.last <= 1'b0;
                        p2_ff <= p2_ff + 1'b1;
                     end else begin
                        out_ff.char_out <= cs_ff;
                        out_ff.last <= (k_ff + 1'b1 == nsub_ff) &&
                                       (p1_ff + 1'b1 >= n_ff) &&
                                       (p2_ff + 1'b1 >= m_ff);
                        p1_ff <= p1_ff + 1'b1; p2_ff <= p2_ff + 1'b1;
                        k_ff  <= k_ff + 1'b1;
                     end
                     state_ff <= ST_WALK;
                  end else if (p1_ff < n_ff) begin
                     out_ff <= '{char_out: c1_ff, empty_res: 1'b0,
                                 overflow: drop_ff,
                                 last: (p1_ff + 1'b1 == n_ff) && (p2_ff >= m_ff)};
                     p1_ff <= p1_ff + 1'b1;
                     state_ff <= ST_WALK;
                  end else if (p2_ff < m_ff) begin
                     out_ff <= '{char_out: c2_ff, empty_res: 1'b0,
                                 overflow: drop_ff, last: (p2_ff + 1'b1 == m_ff)};
                     p2_ff <= p2_ff + 1'b1;
                     state_ff <= ST_WALK;
                  end else begin
                     n_ff <= '0; m_ff <= '0; drop_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_ff <= '{char_out: 8'd0, last: 1'b1,
                              empty_res: 1'b1, overflow: drop_ff};
                  n_ff <= '0; m_ff <= '0; drop_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/shortest_common_supersequence_top.sv @@
// ----------------------------------------------------------------------------
// Shortest common supersequence top
// Accepts string bytes and compute commands and returns the supersequence.
// ----------------------------------------------------------------------------
// The req channel carries one item per transfer: a byte for the first string,
// a byte for the second string, or a compute command. Bytes past MAX_LEN are
// dropped and flagged. A compute command returns the supersequence on the rsp
// channel, one byte per transfer, with last on the final one; two empty
// strings give a single transfer marked empty_res.
// Items enter a four-entry queue, and the engine takes one from it while it
// is idle; it takes no item while a compute runs. A compute fills the (n+1)
// by (m+1) table cell by cell through the single table read port, then
// traces one LCS back through the table and walks it against both strings.
// Reset empties the queue and clears both string lengths and the overflow
// flag. While rsp_stall is high the output register holds its transfer and
// the engine waits to emit the next byte; req items still fill the queue until it is full.
// ----------------------------------------------------------------------------
module shortest_common_supersequence_top
   import scs_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    q_full, q_valid, q_take;
   req_type q_data;

   assign req_stall = q_full;

   scs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .full     (q_full),
      .wr_data  (req_data),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_data  (q_data)
   );

   scs_engine #(.MAX_LEN(MAX_LEN)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_take   (q_take),
      .in_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/tb_shortest_common_supersequence_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shortest common supersequence testbench
// Loads pairs of strings through the req channel and checks every rsp
// transfer against a local model of the supersequence walk, under random idling.
// ----------------------------------------------------------------------------
module tb_shortest_common_supersequence_top;
   import scs_pkg::*;

   localparam int LEN_CAP = MAX_LEN_DEF;
   localparam int GAP_LIMIT = 40000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   shortest_common_supersequence_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   logic [7:0] str_a [LEN_CAP];
   logic [7:0] str_b [LEN_CAP];
   int         len_a;
   int         len_b;
   logic       bytes_dropped;
   rsp_type    scs_expected [$];

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_rsp;
   int  error_count;
   int  items_sent;
   int  bytes_seen;
   int  computes_sent;
   int  idle_cycles;
   bit  timed_out;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_type make_rsp(logic [7:0] ch, logic emp);
      rsp_type r;
      r.char_out  = ch;
      r.last      = 1'b0;
      r.empty_res = emp;
      r.overflow  = bytes_dropped;
      return r;
   endfunction

   task automatic predict_supersequence();
      int         lcs [LEN_CAP + 1][LEN_CAP + 1];
      logic [7:0] common [$];
      int         i;
      int         j;
      int         pa;
      int         pb;
      int         first_new;
      first_new = scs_expected.size();
      if (len_a == 0 && len_b == 0) begin
         scs_expected = {scs_expected, make_rsp(8'h00, 1'b1)};
      end else begin
         for (i = 0; i <= len_a; i++) lcs[i][len_b] = 0;
         for (j = 0; j <= len_b; j++) lcs[len_a][j] = 0;
         for (i = len_a - 1; i >= 0; i--) begin
            for (j = len_b - 1; j >= 0; j--) begin
               if (str_a[i] == str_b[j]) lcs[i][j] = lcs[i + 1][j + 1] + 1;
               else lcs[i][j] = (lcs[i + 1][j] >= lcs[i][j + 1]) ? lcs[i + 1][j]
                                                                 : lcs[i][j + 1];
            end
         end
         i = 0;
         j = 0;
         while (i < len_a && j < len_b) begin
            if (str_a[i] == str_b[j]) begin
               common = {common, str_a[i]};
               i++;
               j++;
            end else if (lcs[i + 1][j] >= lcs[i][j + 1]) begin
               i++;
            end else begin
               j++;
            end
         end
         pa = 0;
         pb = 0;
         foreach (common[k]) begin
            while (pa < len_a && str_a[pa] != common[k]) begin
               scs_expected = {scs_expected, make_rsp(str_a[pa], 1'b0)};
               pa++;
            end
            while (pb < len_b && str_b[pb] != common[k]) begin
               scs_expected = {scs_expected, make_rsp(str_b[pb], 1'b0)};
               pb++;
            end
            scs_expected = {scs_expected, make_rsp(common[k], 1'b0)};
            pa++;
            pb++;
         end
         while (pa < len_a) begin
            scs_expected = {scs_expected, make_rsp(str_a[pa], 1'b0)};
            pa++;
         end
         while (pb < len_b) begin
            scs_expected = {scs_expected, make_rsp(str_b[pb], 1'b0)};
            pb++;
         end
      end
      if (scs_expected.size() > first_new)
         scs_expected[scs_expected.size() - 1].last = 1'b1;
   endtask

   task automatic apply_item(req_type it);
      case (kind_type'(it.kind))
         KIND_FIRST: begin
            if (len_a < LEN_CAP) begin
               str_a[len_a] = it.char_in;
               len_a++;
            end else begin
               bytes_dropped = 1'b1;
            end
         end
         KIND_SECOND: begin
            if (len_b < LEN_CAP) begin
               str_b[len_b] = it.char_in;
               len_b++;
            end else begin
               bytes_dropped = 1'b1;
            end
         end
         KIND_COMPUTE: begin
            predict_supersequence();
            computes_sent++;
            len_a = 0;
            len_b = 0;
            bytes_dropped = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic send_item(logic [1:0] kind, logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, char_in: ch};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_item('{kind: kind, char_in: ch});
      items_sent++;
   endtask

   task automatic send_string_pair(int na, int nb, int alpha);
      int k;
      for (k = 0; k < na; k++) send_item(KIND_FIRST, 8'($urandom_range(alpha - 1)));
      for (k = 0; k < nb; k++) send_item(KIND_SECOND, 8'($urandom_range(alpha - 1)));
      send_item(KIND_COMPUTE, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scs_expected.size() != 0) @(posedge clock);
   endtask

   typedef struct {
      logic [1:0] kind;
      logic [7:0] ch;
      bit         check_now;
      rsp_type    want;
   } step_row;

   step_row steps [] = '{
      '{KIND_COMPUTE, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{KIND_FIRST,   8'hff, 1'b0, '0},
      '{KIND_COMPUTE, 8'hff, 1'b1, '{8'hff, 1'b1, 1'b0, 1'b0}},
      '{KIND_SECOND,  8'h00, 1'b0, '0},
      '{KIND_COMPUTE, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{KIND_NONE,    8'h5a, 1'b0, '0},
      '{KIND_FIRST,   8'h41, 1'b0, '0},
      '{KIND_FIRST,   8'h42, 1'b0, '0},
      '{KIND_SECOND,  8'h42, 1'b0, '0},
      '{KIND_SECOND,  8'h41, 1'b0, '0},
      '{KIND_COMPUTE, 8'h00, 1'b0, '0},
      '{KIND_FIRST,   8'h55, 1'b0, '0},
      '{KIND_SECOND,  8'haa, 1'b0, '0},
      '{KIND_COMPUTE, 8'h00, 1'b0, '0},
      '{KIND_FIRST,   8'h80, 1'b0, '0},
      '{KIND_SECOND,  8'h80, 1'b0, '0},
      '{KIND_COMPUTE, 8'h00, 1'b0, '0},
      '{KIND_NONE,    8'h00, 1'b0, '0}
   };

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_seen++;
         if (scs_expected.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual %p", $time,
                     rsp_data);
            error_count++;
         end else begin
            want = scs_expected.pop_front();
            if (rsp_data.char_out !== want.char_out && !want.empty_res) begin
               $display("%0t: char_out expected %h actual %h", $time,
                        want.char_out, rsp_data.char_out);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_data.last);
               error_count++;
            end
            if (rsp_data.empty_res !== want.empty_res) begin
               $display("%0t: empty_res expected %b actual %b", $time,
                        want.empty_res, rsp_data.empty_res);
               error_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $display("%0t: overflow expected %b actual %b", $time,
                        want.overflow, rsp_data.overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= GAP_LIMIT) begin
         $display("shortest_common_supersequence_top test failed");
         $finish;
      end
   end

   initial begin
      int hold_count;
      hold_rsp = 1'b0;
      wait (items_sent >= 150);
      hold_rsp = 1'b1;
      for (hold_count = 0; hold_count < 3000; hold_count++) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int n;
      int phase;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      len_a         = 0;
      len_b         = 0;
      bytes_dropped = 1'b0;
      error_count   = 0;
      items_sent    = 0;
      bytes_seen    = 0;
      computes_sent = 0;
      idle_cycles   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[s]) begin
         send_item(steps[s].kind, steps[s].ch);
         if (steps[s].check_now) begin
            if (scs_expected.size() == 0 ||
                scs_expected[scs_expected.size() - 1] !== steps[s].want) begin
               $display("%0t: row %0d expected %p, predictor gives %p", $time, s,
                        steps[s].want, (scs_expected.size() == 0) ? rsp_type'('0)
                        : scs_expected[scs_expected.size() - 1]);
               error_count++;
            end
            wait_drained();
         end
      end
      wait_drained();
      for (n = 0; n < LEN_CAP + 2; n++) send_item(KIND_FIRST, 8'($urandom));
      for (n = 0; n < LEN_CAP + 2; n++) send_item(KIND_SECOND, 8'($urandom));
      send_item(KIND_COMPUTE, 8'h00);
      send_item(KIND_SECOND, 8'h01);
      send_item(KIND_SECOND, 8'hfe);
      send_item(KIND_COMPUTE, 8'h00);

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 50 : 0;
         recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 22 : 0;
         while (items_sent < 150 * (phase + 1) + 20) begin
            n = $urandom_range(99);
            if (n < 8) send_item(2'($urandom_range(3)), 8'($urandom));
            else if (n < 12) send_string_pair($urandom_range(40), $urandom_range(40), 256);
            else send_string_pair($urandom_range(8), $urandom_range(8),
                                  $urandom_range(1) ? 4 : 256);
         end
      end
      send_item(KIND_COMPUTE, 8'h00);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Sent %0d items with %0d compute commands; checked %0d result bytes.",
               items_sent, computes_sent, bytes_seen);
      if (error_count == 0 && scs_expected.size() == 0) begin
         $display("shortest_common_supersequence_top test passed");
      end else begin
         $display("shortest_common_supersequence_top test failed");
      end
      $finish;
   end

endmodule
